// ----- src/icosub_pkg.sv -----
// ----------------------------------------------------------------------------
// icosub_pkg
// Shared types and constants of the icosphere triangle subdivider.
// ----------------------------------------------------------------------------
package icosub_pkg;

  localparam int VTX_W     = 14;              // vertex index width
  localparam int NV_W      = 15;              // next-free counter width
  localparam int COORD_W   = 18;              // signed Q2.16 coordinate
  localparam int SUM_W     = COORD_W + 1;     // sum of two coordinates
  localparam int TRI_W     = 13;              // triangle position j
  localparam int SLOTS     = 6;               // midpoint slots per vertex
  localparam int NUM_VTX   = 1 << VTX_W;
  localparam int SLOT_IDX_W = $clog2(SLOTS);

  // input commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_LEVEL = 2'd1;
  localparam logic [1:0] CMD_SPLIT = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_VTX = 2'd0;
  localparam logic [1:0] KIND_TRI = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  // one midpoint table slot
  typedef struct packed {
    logic             valid;
    logic [VTX_W-1:0] partner;
    logic [VTX_W-1:0] mid;
  } slot_t;

  typedef slot_t [SLOTS-1:0] tb_row_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

endpackage

// ----- src/icosub_norm.sv -----
// ----------------------------------------------------------------------------
// icosub_norm
// Vector normalizer: exact squared length, bit-serial integer square root
// and bit-serial rounded division of each component.
// ----------------------------------------------------------------------------
module icosub_norm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  icosub_pkg::sum_t vec_x,
  input  icosub_pkg::sum_t vec_y,
  input  icosub_pkg::sum_t vec_z,
  output logic             done,
  output icosub_pkg::coord_t res_x,
  output icosub_pkg::coord_t res_y,
  output icosub_pkg::coord_t res_z
);
  import icosub_pkg::*;

  localparam int MAG_W  = SUM_W;          // magnitude up to 2^18
  localparam int N2_W   = 2 * MAG_W;      // squared length
  localparam int N_W    = N2_W + 16;      // radicand
  localparam int ACC_W  = N_W + 2;        // root working width
  localparam int ROOT_W = 28;             // square root width
  localparam int Q_W    = 18;             // quotient bits
  localparam int D_W    = MAG_W + 25;     // dividend (mag<<25) + s
  localparam int DV_W   = ROOT_W + 1;     // divisor 2s
  localparam int REM_W  = DV_W + 1;

  typedef enum logic [2:0] {N_IDLE, N_SQ, N_ROOT, N_DLD, N_DIV, N_DONE} nstate_t;

  nstate_t             state_r;
  logic [1:0]          cnt_r;             // component counter
  logic [4:0]          it_r;              // iteration counter
  logic [MAG_W-1:0]    mag_r [3];
  logic [2:0]          neg_r;
  logic [N2_W-1:0]     acc_r;
  logic [ACC_W-1:0]    sq_n_r, sq_res_r, sq_bit_r;
  logic [ROOT_W-1:0]   s_r;
  logic [REM_W-1:0]    rem_r;
  logic [Q_W-1:0]      low_r, quo_r;
  coord_t              out_r [3];

  logic [N2_W-1:0]     sq_prod;
  logic [ACC_W-1:0]    sq_try;
  logic [D_W-1:0]      dvd;
  logic [DV_W-1:0]     dvs;
  logic [REM_W-1:0]    rem_sh;
  logic [Q_W-1:0]      quo_nxt;
  coord_t              comp_val;

  // magnitude square and root step
  assign sq_prod = N2_W'(mag_r[cnt_r]) * N2_W'(mag_r[cnt_r]);
  assign sq_try  = sq_res_r + sq_bit_r;

  // division step
  assign dvd     = {mag_r[cnt_r], 25'b0} + D_W'(s_r);
  assign dvs     = {s_r, 1'b0};
  assign rem_sh  = {rem_r[REM_W-2:0], low_r[Q_W-1]};
  assign quo_nxt = {quo_r[Q_W-2:0], (rem_sh >= REM_W'(dvs))};

  // saturate and apply sign to the finished quotient; a zero root gives zero
  always_comb begin
    if (s_r == '0) begin
      comp_val = '0;
    end else if (neg_r[cnt_r]) begin
      if (quo_nxt > Q_W'(131072)) comp_val = coord_t'(-131072);
      else comp_val = coord_t'(-$signed({1'b0, quo_nxt}));
    end else begin
      if (quo_nxt > Q_W'(131071)) comp_val = coord_t'(131071);
      else comp_val = coord_t'(quo_nxt);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      cnt_r   <= '0;
      it_r    <= '0;
    end else begin
      unique case (state_r)
        N_IDLE: begin
          if (start) begin
            mag_r[0] <= vec_x[SUM_W-1] ? MAG_W'(-vec_x) : MAG_W'(vec_x);
            mag_r[1] <= vec_y[SUM_W-1] ? MAG_W'(-vec_y) : MAG_W'(vec_y);
            mag_r[2] <= vec_z[SUM_W-1] ? MAG_W'(-vec_z) : MAG_W'(vec_z);
            neg_r    <= {vec_z[SUM_W-1], vec_y[SUM_W-1], vec_x[SUM_W-1]};
            acc_r    <= '0;
            cnt_r    <= '0;
            state_r  <= N_SQ;
          end
        end
        N_SQ: begin
          acc_r <= acc_r + sq_prod;
          if (cnt_r == 2'd2) begin
            cnt_r   <= '0;
            it_r    <= '0;
            state_r <= N_ROOT;
          end else begin
            cnt_r <= cnt_r + 2'd1;
          end
        end
        N_ROOT: begin
          // first cycle loads the radicand, then one root bit per cycle
          if (it_r == 5'd0) begin
            sq_n_r   <= ACC_W'({acc_r, 16'b0});
            sq_res_r <= '0;
            sq_bit_r <= ACC_W'(1) << (N_W - 2);
            it_r     <= 5'd1;
          end else begin
            if (sq_n_r >= sq_try) begin
              sq_n_r   <= sq_n_r - sq_try;
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
            if (it_r == 5'(ROOT_W - 1)) begin
              cnt_r   <= '0;
              state_r <= N_DLD;
            end else begin
              it_r <= it_r + 5'd1;
            end
          end
        end
        N_DLD: begin
          if (cnt_r == 2'd0) s_r <= sq_res_r[ROOT_W-1:0];
          state_r <= N_DIV;
          it_r    <= '0;
          if (cnt_r == 2'd0) begin
            rem_r <= REM_W'(({mag_r[0], 25'b0} + D_W'(sq_res_r[ROOT_W-1:0])) >> Q_W);
            low_r <= Q_W'({mag_r[0], 25'b0} + D_W'(sq_res_r[ROOT_W-1:0]));
          end else begin
            rem_r <= REM_W'(dvd >> Q_W);
            low_r <= dvd[Q_W-1:0];
          end
          quo_r <= '0;
        end
        N_DIV: begin
          rem_r <= (rem_sh >= REM_W'(dvs)) ? rem_sh - REM_W'(dvs) : rem_sh;
          low_r <= {low_r[Q_W-2:0], 1'b0};
          quo_r <= quo_nxt;
          if (it_r == 5'(Q_W - 1)) begin
            out_r[cnt_r] <= comp_val;
            if (cnt_r == 2'd2) begin
              state_r <= N_DONE;
            end else begin
              cnt_r   <= cnt_r + 2'd1;
              state_r <= N_DLD;
            end
          end else begin
            it_r <= it_r + 5'd1;
          end
        end
        N_DONE: state_r <= N_IDLE;
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign done  = (state_r == N_DONE);
  assign res_x = out_r[0];
  assign res_y = out_r[1];
  assign res_z = out_r[2];

endmodule

// ----- src/icosphere_triangle_subdivider_top.sv -----
// ----------------------------------------------------------------------------
// icosphere_triangle_subdivider_top
// Splits icosphere triangles into four, sharing edge midpoints via a table.
// ----------------------------------------------------------------------------
// One item is handled at a time. A load runs the normalizer (three squares,
// a 27-step square root and three 18-step divisions). A refine looks up
// each edge in the table, runs the normalizer for each new midpoint and
// then emits its results. After reset and after each begin_level the
// midpoint table is swept clear one row per cycle, while no input is
// taken. A finished result waits in an output register while the next
// input is taken.
module icosphere_triangle_subdivider_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vertex_index, coord_x, coord_y, coord_z, corner_a, corner_b,
  // corner_c, triangle_index
  input  logic [127:0] in_tdata,
  input  logic [1:0]   in_tuser,    // command
  output logic         out_tvalid,
  input  logic         out_tready,
  // item_index, pos_x, pos_y, pos_z, tri_first, tri_second, tri_third
  output logic [111:0] out_tdata,
  output logic [1:0]   out_tuser,   // kind
  output logic         out_tlast    // last
);
  import icosub_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LSTART, S_LWAIT, S_TRD, S_TCHK, S_VLO, S_VHI, S_VSUM,
    S_NWAIT, S_EMITV, S_EMITT, S_EMITE
  } state_t;

  state_t            state_r;
  logic [NV_W-1:0]   clr_r;
  logic [NV_W-1:0]   nv_r;
  logic [VTX_W-1:0]  vi_r, a_r, b_r, c_r;
  logic [TRI_W-1:0]  j_r;
  logic [1:0]        edge_r, tk_r;
  logic [VTX_W-1:0]  mid_r [3];
  logic [SLOT_IDX_W-1:0] free_r;
  coord_t            lx_r, ly_r, lz_r;
  coord_t            px_r, py_r, pz_r;

  // memories
  logic [3*COORD_W-1:0] vs_mem [NUM_VTX];
  logic [3*COORD_W-1:0] vs_rdata_r, vs_wdata;
  logic [VTX_W-1:0]     vs_raddr, vs_waddr;
  logic                 vs_re, vs_we;
  tb_row_t              tb_mem [NUM_VTX];
  tb_row_t              tb_rdata_r, tb_wdata;
  logic [VTX_W-1:0]     tb_raddr, tb_waddr;
  logic                 tb_re, tb_we;

  // normalizer
  logic   nm_start, nm_done;
  sum_t   nm_x, nm_y, nm_z;
  coord_t nm_rx, nm_ry, nm_rz;

  // output register
  logic         out_valid_r, out_last_r;
  logic [1:0]   out_kind_r;
  logic [111:0] out_data_r;

  // edge ends and table search
  logic [VTX_W-1:0] ep, eq, lo, hi;
  logic             hit, has_free;
  logic [VTX_W-1:0] hit_mid;
  logic [SLOT_IDX_W-1:0] free_idx;
  logic             emit_ok, emit_req;
  logic [VTX_W-1:0] t0, t1, t2;

  always_comb begin
    unique case (edge_r)
      2'd0:    begin ep = a_r; eq = b_r; end
      2'd1:    begin ep = a_r; eq = c_r; end
      default: begin ep = b_r; eq = c_r; end
    endcase
    lo = (ep < eq) ? ep : eq;
    hi = (ep < eq) ? eq : ep;
  end

  always_comb begin
    hit      = 1'b0;
    hit_mid  = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (tb_rdata_r[i].valid) begin
        if (tb_rdata_r[i].partner == hi) begin
          hit     = 1'b1;
          hit_mid = tb_rdata_r[i].mid;
        end
      end else begin
        has_free = 1'b1;
        free_idx = SLOT_IDX_W'(i);
      end
    end
  end

  // memory control
  always_comb begin
    vs_re    = 1'b0;
    vs_raddr = lo;
    vs_we    = 1'b0;
    vs_waddr = nv_r[VTX_W-1:0];
    vs_wdata = {nm_rz, nm_ry, nm_rx};
    tb_re    = (state_r == S_TRD);
    tb_raddr = lo;
    tb_we    = 1'b0;
    tb_waddr = lo;
    tb_wdata = tb_rdata_r;
    if (state_r == S_VLO) vs_re = 1'b1;
    if (state_r == S_VHI) begin
      vs_re    = 1'b1;
      vs_raddr = hi;
    end
    if (state_r == S_LWAIT && nm_done) begin
      vs_we    = 1'b1;
      vs_waddr = vi_r;
    end
    if (state_r == S_NWAIT && nm_done) begin
      vs_we = 1'b1;
      tb_we = 1'b1;
      tb_wdata[free_r] = '{valid: 1'b1, partner: hi, mid: nv_r[VTX_W-1:0]};
    end
    if (state_r == S_CLR) begin
      tb_we    = 1'b1;
      tb_waddr = clr_r[VTX_W-1:0];
      tb_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (vs_we) vs_mem[vs_waddr] <= vs_wdata;
    if (vs_re) vs_rdata_r <= vs_mem[vs_raddr];
  end

  always_ff @(posedge clk) begin
    if (tb_we) tb_mem[tb_waddr] <= tb_wdata;
    if (tb_re) tb_rdata_r <= tb_mem[tb_raddr];
  end

  // normalizer input: raw point for a load, end sum for a midpoint
  assign nm_start = (state_r == S_LSTART) || (state_r == S_VSUM);
  always_comb begin
    if (state_r == S_LSTART) begin
      nm_x = sum_t'(lx_r);
      nm_y = sum_t'(ly_r);
      nm_z = sum_t'(lz_r);
    end else begin
      nm_x = sum_t'(lx_r) + sum_t'($signed(vs_rdata_r[COORD_W-1:0]));
      nm_y = sum_t'(ly_r) + sum_t'($signed(vs_rdata_r[2*COORD_W-1:COORD_W]));
      nm_z = sum_t'(lz_r) + sum_t'($signed(vs_rdata_r[3*COORD_W-1:2*COORD_W]));
    end
  end

  icosub_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nm_start),
    .vec_x (nm_x),
    .vec_y (nm_y),
    .vec_z (nm_z),
    .done  (nm_done),
    .res_x (nm_rx),
    .res_y (nm_ry),
    .res_z (nm_rz)
  );

  // child triangle corners by position
  always_comb begin
    unique case (tk_r)
      2'd3:    begin t0 = a_r;      t1 = mid_r[0]; t2 = mid_r[1]; end
      2'd2:    begin t0 = b_r;      t1 = mid_r[2]; t2 = mid_r[0]; end
      2'd1:    begin t0 = c_r;      t1 = mid_r[1]; t2 = mid_r[2]; end
      default: begin t0 = mid_r[1]; t1 = mid_r[0]; t2 = mid_r[2]; end
    endcase
  end

  assign emit_ok   = !out_valid_r || out_tready;
  assign emit_req  = (state_r == S_EMITV) || (state_r == S_EMITT) || (state_r == S_EMITE);
  assign in_tready = (state_r == S_IDLE);

  // control sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      nv_r        <= '0;
      out_valid_r <= 1'b0;
      edge_r      <= '0;
      tk_r        <= '0;
    end else begin
      if (out_valid_r && out_tready && !emit_req) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + NV_W'(1);
          if (clr_r[VTX_W-1:0] == VTX_W'(NUM_VTX - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            vi_r <= in_tdata[13:0];
            lx_r <= in_tdata[31:14];
            ly_r <= in_tdata[49:32];
            lz_r <= in_tdata[67:50];
            a_r  <= in_tdata[81:68];
            b_r  <= in_tdata[95:82];
            c_r  <= in_tdata[109:96];
            j_r  <= in_tdata[122:110];
            edge_r <= '0;
            unique case (in_tuser)
              CMD_LOAD:  state_r <= S_LSTART;
              CMD_LEVEL: begin
                nv_r    <= NV_W'(in_tdata[13:0]);
                clr_r   <= '0;
                state_r <= S_CLR;
              end
              CMD_SPLIT: state_r <= S_TRD;
              default:   state_r <= S_IDLE;
            endcase
          end
        end
        S_LSTART: state_r <= S_LWAIT;
        S_LWAIT:  if (nm_done) state_r <= S_IDLE;
        S_TRD:    state_r <= S_TCHK;
        S_TCHK: begin
          free_r <= free_idx;
          if (hit) begin
            mid_r[edge_r] <= hit_mid;
            if (edge_r == 2'd2) begin
              tk_r    <= 2'd3;
              state_r <= S_EMITT;
            end else begin
              edge_r  <= edge_r + 2'd1;
              state_r <= S_TRD;
            end
          end else if (!has_free || nv_r[VTX_W]) begin
            state_r <= S_EMITE;
          end else begin
            state_r <= S_VLO;
          end
        end
        S_VLO: state_r <= S_VHI;
        S_VHI: begin
          lx_r    <= vs_rdata_r[COORD_W-1:0];
          ly_r    <= vs_rdata_r[2*COORD_W-1:COORD_W];
          lz_r    <= vs_rdata_r[3*COORD_W-1:2*COORD_W];
          state_r <= S_VSUM;
        end
        S_VSUM: state_r <= S_NWAIT;
        S_NWAIT: begin
          if (nm_done) begin
            px_r          <= nm_rx;
            py_r          <= nm_ry;
            pz_r          <= nm_rz;
            mid_r[edge_r] <= nv_r[VTX_W-1:0];
            state_r       <= S_EMITV;
          end
        end
        S_EMITV: begin
          if (emit_ok) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_VTX;
            out_last_r  <= 1'b0;
            out_data_r  <= {1'b0, 42'b0, pz_r, py_r, px_r, nv_r};
            nv_r        <= nv_r + NV_W'(1);
            if (edge_r == 2'd2) begin
              tk_r    <= 2'd3;
              state_r <= S_EMITT;
            end else begin
              edge_r  <= edge_r + 2'd1;
              state_r <= S_TRD;
            end
          end
        end
        S_EMITT: begin
          if (emit_ok) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_TRI;
            out_last_r  <= (tk_r == 2'd0);
            out_data_r  <= {1'b0, t2, t1, t0, 54'b0, j_r, tk_r};
            tk_r        <= tk_r - 2'd1;
            if (tk_r == 2'd0) state_r <= S_IDLE;
          end
        end
        S_EMITE: begin
          if (emit_ok) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_ERR;
            out_last_r  <= 1'b1;
            out_data_r  <= {1'b0, 42'b0, 54'b0, 2'b0, j_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- src/icosub_chk.sv -----
// ----------------------------------------------------------------------------
// icosub_chk
// Port-level checks of the subdivider's result stream.
// ----------------------------------------------------------------------------
module icosub_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);
  import icosub_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // an error always closes the step
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ERR |-> out_tlast)
    else $error("error result without last");

  // a new vertex never closes the step
  a_vtx_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_VTX |-> !out_tlast)
    else $error("vertex result marked last");

  // triangles carry no position
  a_tri_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_TRI |-> out_tdata[68:15] == '0)
    else $error("triangle result with position bits");

endmodule

bind icosphere_triangle_subdivider_top icosub_chk u_icosub_chk (.*);
